// ===== design/est_pkg.sv =====
// ----------------------------------------------------------------------------
// est_pkg: shared types and constants for the expiring slot table
// Operation codes, timeout limits, the reciprocal used for the ms-to-tick
// division and the layout of one stored entry.
// ----------------------------------------------------------------------------
package est_pkg;

  localparam int SLOTS_DEF = 6;

  // operation codes carried in the input tuser
  localparam logic [1:0] FUNC_POST    = 2'd0;
  localparam logic [1:0] FUNC_TICK    = 2'd1;
  localparam logic [1:0] FUNC_DISMISS = 2'd2;

  localparam int MS_W  = 16;  // clamped timeout, up to 60000
  localparam int HZ_W  = 14;
  localparam int LIF_W = 20;

  localparam logic [31:0]     DEF_TIMEOUT_MS = 32'd7000;
  localparam logic [31:0]     MIN_MS         = 32'd1000;
  localparam logic [31:0]     MAX_MS         = 32'd60000;
  localparam logic [HZ_W-1:0] DEF_RATE       = 14'd100;
  localparam logic [29:0]     ROUND_UP       = 30'd999;
  localparam logic [31:0]     ORDER_MAX      = 32'hFFFF_FFFF;

  // floor(x / 1000) = (x * RECIP) >> RECIP_SHIFT, exact for x < 2^30
  localparam logic [30:0] RECIP       = 31'd1099511628;
  localparam int          RECIP_SHIFT = 40;

  typedef struct packed {
    logic [1:0]       level;
    logic [31:0]      order;
    logic [31:0]      birth;
    logic [LIF_W-1:0] lifetime;
  } entry_t;

endpackage

// ===== design/est_ram.sv =====
// ----------------------------------------------------------------------------
// est_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module est_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/expiring_slot_table.sv =====
// ----------------------------------------------------------------------------
// expiring_slot_table: timed entry table with oldest-entry eviction
// Posts, ticks and dismisses entries; one result per input transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis_*): tuser selects the operation (post, tick,
//   dismiss); tdata carries the level and the timeout in ms for a post.
//   Output stream (m_axis_*): exactly one result transaction per input
//   transaction, in order.
//   cfg_we/cfg_data write tick_rate_hz; write it only while the block idles.
// Timing:
//   The block handles one transaction at a time. A single compare unit walks
//   the slots, one per cycle, behind the registered read of the entry RAM.
//   post:    accept, scan of the slots, entry write, result load
//   tick:    accept, scan of the slots, result load
//   dismiss and the unused code: accept, result load
//   The ms-to-tick conversion (two multipliers, registered) runs during the
//   scan. s_axis_tready is high only between transactions.
// Reset (rst, synchronous): all entries dead, time and sequence counters
//   zero, rate 100. The entry RAM is not cleared; only live entries' data is used.
// Stall: a finished result sits in the output register until taken; the
//   next transaction can be accepted meanwhile, and its result waits in the
//   final state until the output register is free.
// ----------------------------------------------------------------------------
module expiring_slot_table
  import est_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input: tuser = func[1:0]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // input: tdata = level[7:0], timeout[39:8]
  input  logic [39:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // output: tdata = slot[2:0], seq_number[34:3], evicted[35],
  //   removed_count[38:36], active_count[41:39], full_redraw[42],
  //   content_redraw[43], zero[47:44]
  output logic [47:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [13:0] cfg_data
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]       state;
  logic [HZ_W-1:0]  tick_rate_hz;
  logic [31:0]      time_now;
  logic [31:0]      order_counter;
  logic [SLOTS-1:0] live;
  logic [CW-1:0]    active_cnt;

  // per-transaction registers
  logic [1:0]       func;
  logic [1:0]       lvl;
  logic [MS_W-1:0]  ms_c;
  logic [IW-1:0]    scan_idx;
  logic             iss_done;
  logic             prc_vld;
  logic [IW-1:0]    prc_idx;
  logic [CW-1:0]    removed_cnt;
  logic             free_found;
  logic [IW-1:0]    vacant_slot;
  logic [31:0]      best_order;
  logic [IW-1:0]    best_slot;
  logic [29:0]      prod_hz;
  logic [60:0]      prod_div;

  // result fields
  logic [IW-1:0]    res_slot;
  logic [31:0]      res_seq;
  logic             res_evicted;
  logic [CW-1:0]    res_removed;
  logic [CW-1:0]    res_active;
  logic             res_full;
  logic             res_content;
  logic             res_load;

  logic             in_acc;
  logic [1:0]       in_func;
  logic [7:0]       in_level;
  logic [31:0]      in_ms;
  logic [31:0]      ms_dflt;
  logic [31:0]      ms_clamp;
  logic [HZ_W-1:0]  hz_eff;

  entry_t           rd_ent;
  entry_t           wr_ent;
  logic [31:0]      elapsed;
  logic             cur_live;
  logic             cur_exp;
  logic             cur_free;
  logic [IW-1:0]    wr_slot;
  logic             wr_en;

  assign in_func  = s_axis_tuser;
  assign in_level = s_axis_tdata[7:0];
  assign in_ms    = s_axis_tdata[39:8];
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);

  // result register loads only when empty or being drained this cycle
  assign res_load = (state == S_DONE) && (!m_axis_tvalid || m_axis_tready);

  // timeout defaulting and clamping
  assign ms_dflt  = (in_ms == 32'd0) ? DEF_TIMEOUT_MS : in_ms;
  assign ms_clamp = (ms_dflt < MIN_MS) ? MIN_MS :
                    (ms_dflt > MAX_MS) ? MAX_MS : ms_dflt;
  assign hz_eff   = (tick_rate_hz == '0) ? DEF_RATE : tick_rate_hz;

  // shared compare unit: one slot per cycle
  assign cur_live = live[prc_idx];
  assign elapsed  = time_now - rd_ent.birth;
  assign cur_exp  = cur_live && (rd_ent.lifetime != '0) &&
                    (elapsed >= {{(32-LIF_W){1'b0}}, rd_ent.lifetime});
  assign cur_free = !cur_live || cur_exp;

  assign wr_slot  = free_found ? vacant_slot : best_slot;
  assign wr_en    = (state == S_WRITE);
  assign wr_ent   = '{level: lvl, order: order_counter + 32'd1, birth: time_now,
                      lifetime: prod_div[RECIP_SHIFT+LIF_W-1:RECIP_SHIFT]};

  est_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_slot),
    .wdata (wr_ent),
    .raddr (scan_idx),
    .rdata (rd_ent)
  );

  // ms * rate, then ceil(/1000) via reciprocal; free-running during the scan
  always_ff @(posedge clk) begin
    prod_hz  <= {14'd0, ms_c} * {16'd0, hz_eff};
    prod_div <= {31'd0, prod_hz + ROUND_UP} * {30'd0, RECIP};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      tick_rate_hz  <= DEF_RATE;
      time_now      <= '0;
      order_counter <= '0;
      live          <= '0;
      active_cnt    <= '0;
      m_axis_tvalid <= 1'b0;
      prc_vld       <= 1'b0;
      iss_done      <= 1'b0;
    end else begin
      if (cfg_we) begin
        tick_rate_hz <= cfg_data;
      end
      if (res_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_acc) begin
            func        <= in_func;
            lvl         <= (in_level <= 8'd2) ? in_level[1:0] : 2'd0;
            ms_c        <= ms_clamp[MS_W-1:0];
            scan_idx    <= '0;
            iss_done    <= 1'b0;
            prc_vld     <= 1'b0;
            removed_cnt <= (in_func == FUNC_DISMISS) ? active_cnt : '0;
            free_found  <= 1'b0;
            vacant_slot <= '0;
            best_order  <= ORDER_MAX;
            best_slot   <= '0;
            case (in_func)
              FUNC_POST: begin
                state <= S_SCAN;
              end
              FUNC_TICK: begin
                time_now <= time_now + 32'd1;
                state    <= S_SCAN;
              end
              FUNC_DISMISS: begin
                active_cnt  <= '0;
                live        <= '0;
                state       <= S_DONE;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end

        S_SCAN: begin
          // issue side: RAM read address walks the slots
          if (!iss_done) begin
            prc_vld <= 1'b1;
            prc_idx <= scan_idx;
            if (scan_idx == LAST) begin
              iss_done <= 1'b1;
            end else begin
              scan_idx <= scan_idx + IW'(1);
            end
          end else begin
            prc_vld <= 1'b0;
          end
          // process side: entry data is the registered read of the previous cycle's address
          if (prc_vld) begin
            if (cur_exp) begin
              live[prc_idx] <= 1'b0;
              removed_cnt   <= removed_cnt + CW'(1);
              active_cnt    <= active_cnt - CW'(1);
            end
            if (cur_free && !free_found) begin
              free_found  <= 1'b1;
              vacant_slot <= prc_idx;
            end
            if (!cur_free && (rd_ent.order < best_order)) begin
              best_order <= rd_ent.order;
              best_slot  <= prc_idx;
            end
            if (prc_idx == LAST) begin
              state <= (func == FUNC_POST) ? S_WRITE : S_DONE;
            end
          end
        end

        S_WRITE: begin
          live[wr_slot] <= 1'b1;
          order_counter <= order_counter + 32'd1;
          if (free_found) begin
            active_cnt <= active_cnt + CW'(1);
          end
          state <= S_DONE;
        end

        S_DONE: begin
          // post fields come from the write just done; zero for other codes
          if (res_load) begin
            res_slot      <= (func == FUNC_POST) ? wr_slot : '0;
            res_seq       <= (func == FUNC_POST) ? order_counter : '0;
            res_evicted   <= (func == FUNC_POST) && !free_found;
            res_removed   <= removed_cnt;
            res_active    <= active_cnt;
            res_full      <= (func == FUNC_POST) ||
                             (((func == FUNC_TICK) || (func == FUNC_DISMISS)) &&
                              (removed_cnt != '0));
            res_content   <= ((func == FUNC_TICK) || (func == FUNC_DISMISS)) &&
                             (removed_cnt != '0);
            state         <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tdata = {4'd0, res_content, res_full, 3'(res_active),
                         3'(res_removed), res_evicted, res_seq, 3'(res_slot)};

  // ---------------------------------------------------------------- checks
  a_active_bound: assert property (@(posedge clk) disable iff (rst)
    active_cnt <= CW'(SLOTS))
    else $error("active count above slot count");

  a_active_matches_live: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ($countones(live) == active_cnt))
    else $error("active count disagrees with live bits");

  a_written_slot_live: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) |=> live[$past(wr_slot)])
    else $error("posted slot not live");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> ($past(state) == S_DONE))
    else $error("result raised outside final state");

  a_content_implies_full: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && res_content) |-> res_full)
    else $error("content redraw without full redraw");

endmodule
